FILE: hdl/cbs_pkg.sv
`default_nettype none

package cbs_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 32;
  localparam int unsigned ADDR_W    = 33;
  localparam int unsigned HDR_W     = 32;
  localparam int unsigned PRIOR_W   = 16;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned RATE_W    = 12;
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned OUT_TDATA_W = ID_W + RATE_W + SIZE_W + IDX_W;

  // Output tdata bit positions
  localparam int unsigned RATE_LSB  = ID_W;
  localparam int unsigned SIZE_LSB  = RATE_LSB + RATE_W;
  localparam int unsigned IDX_LSB   = SIZE_LSB + SIZE_W;

  // Configuration register indexes
  localparam logic CFG_EXTENDED_LAYOUT = 1'b0;
  localparam logic CFG_WIDE_CHANNEL    = 1'b1;

  // Record layout
  localparam logic [POS_W-1:0]  LIMIT_POS_STD  = 32'd3;
  localparam logic [POS_W-1:0]  LIMIT_POS_EXT  = 32'd19;
  localparam logic [ADDR_W-1:0] LIMIT_BIAS_EXT = 33'd20;
  localparam logic [ADDR_W-1:0] FIRST_HDR_STD  = 33'd10;
  localparam logic [ADDR_W-1:0] FIRST_HDR_EXT  = 33'd22;
  localparam logic [ADDR_W-1:0] HDR_TAIL       = 33'd3;
  localparam logic [ADDR_W-1:0] PREFIX_EXT     = 33'd2;
  localparam logic [16:0]       LEN_BIAS       = 17'd8;
  localparam logic [SIZE_W-1:0] MAX_SHORT_SIZE = 4'd4;

  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_SCAN = 2'b10
  } phase_t;

endpackage

`default_nettype wire

FILE: hdl/channel_block_scanner_core.sv
`default_nettype none

// Channel block scanner for a seismic record streamed one byte per transfer.
// Assert in_tuser on the first byte of every record; bytes outside a record
// are dropped. The record limit is taken from the big-endian size at bytes
// 0..3, or bytes 16..19 plus 20 when extended_layout is set. Each 4-byte
// channel block header yields one result, offered from the cycle after its
// last byte is accepted: channel id, sample rate, sample size code and channel
// index in out_tdata, the last-channel flag in out_tlast and the malformed
// flag in out_tuser. The block takes one byte every cycle with no bubbles;
// that rate is set by the combinational header decode (a 4x12 multiply-add,
// a 33-bit block-end add and the limit compare) between the accepted byte
// and the result register. The result register decouples the two sides, so
// a waiting result stalls input only while out_tready is low. There is no
// clearing pass after reset. Registers are read live on every byte; the first
// header position is fixed at record start.
module channel_block_scanner_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic                              cfg_wdata,
  // Input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [cbs_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] data_byte
  input  wire logic                              in_tuser,   // [0] record_start
  // Result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [31:0] channel_id, [43:32] sample_rate, [47:44] sample_size_code,
  // [63:48] channel_index
  output logic [cbs_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tlast,  // last_channel
  output logic                                   out_tuser   // [0] malformed
);

  // Configuration registers
  logic ext_r;
  logic wide_r;

  // Parser state
  cbs_pkg::phase_t                  phase_r,    phase_nxt;
  logic [cbs_pkg::POS_W-1:0]        pos_r,      pos_nxt;
  logic [cbs_pkg::ADDR_W-1:0]       limit_r,    limit_nxt;
  logic [cbs_pkg::HDR_W-1:0]        shift_r,    shift_nxt;
  logic [cbs_pkg::PRIOR_W-1:0]      prior_r,    prior_nxt;
  logic [cbs_pkg::ADDR_W-1:0]       next_hdr_r, next_hdr_nxt;
  logic [cbs_pkg::ADDR_W-1:0]       hdr_end_r,  hdr_end_nxt;
  logic [cbs_pkg::IDX_W-1:0]        count_r,    count_nxt;

  // Result register
  logic                             out_valid_r, out_valid_nxt;
  logic [cbs_pkg::OUT_TDATA_W-1:0]  out_data_r;
  logic                             out_last_r;
  logic                             out_bad_r;

  // Per-byte decode
  logic                             accept;
  logic                             start;
  logic                             active;
  logic [cbs_pkg::HDR_W-1:0]        shift_base;
  logic [cbs_pkg::PRIOR_W-1:0]      prior_base;
  logic [cbs_pkg::ADDR_W-1:0]       next_base;
  logic [cbs_pkg::ADDR_W-1:0]       hdr_end_base;
  logic [cbs_pkg::IDX_W-1:0]        count_base;
  logic                             hit;
  logic [cbs_pkg::RATE_W-1:0]       rate;
  logic [cbs_pkg::SIZE_W-1:0]       size;
  logic [cbs_pkg::ID_W-1:0]         chan_id;
  logic [cbs_pkg::RATE_W+cbs_pkg::SIZE_W-1:0] prod;
  logic [16:0]                      len_wide;
  logic [cbs_pkg::LEN_W-1:0]        len;
  logic                             bad;
  logic [cbs_pkg::ADDR_W-1:0]       block_end;
  logic                             last;

  assign accept = in_tvalid && in_tready;
  assign start  = in_tuser;
  assign active = start || (phase_r == cbs_pkg::PH_SCAN);

  // Keep taking bytes while the result register is empty or draining.
  assign in_tready = !out_valid_r || out_tready;

  // A new record restarts all record state before this byte shifts in.
  always_comb begin
    shift_base   = start ? '0 : shift_r;
    prior_base   = start ? '0 : prior_r;
    count_base   = start ? '0 : count_r;
    next_base    = start ? (ext_r ? cbs_pkg::FIRST_HDR_EXT : cbs_pkg::FIRST_HDR_STD)
                         : next_hdr_r;
    hdr_end_base = start ? (ext_r ? cbs_pkg::FIRST_HDR_EXT + cbs_pkg::HDR_TAIL
                                  : cbs_pkg::FIRST_HDR_STD + cbs_pkg::HDR_TAIL)
                         : hdr_end_r;
    if (start) begin
      pos_nxt = '0;
    end else if (&pos_r) begin
      pos_nxt = pos_r;  // saturate
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
    prior_nxt = {prior_base[7:0], shift_base[cbs_pkg::HDR_W-1 -: 8]};
    shift_nxt = {shift_base[cbs_pkg::HDR_W-9:0], in_tdata};
  end

  // Record limit capture from the size field
  always_comb begin
    limit_nxt = start ? '0 : limit_r;
    if (!ext_r && pos_nxt == cbs_pkg::LIMIT_POS_STD) begin
      limit_nxt = {1'b0, shift_nxt};
    end else if (ext_r && pos_nxt == cbs_pkg::LIMIT_POS_EXT) begin
      limit_nxt = {1'b0, shift_nxt} + cbs_pkg::LIMIT_BIAS_EXT;
    end
  end

  // Header decode on the last byte of a channel block header
  assign hit  = active && ({1'b0, pos_nxt} == hdr_end_base);
  assign rate = shift_nxt[cbs_pkg::RATE_W-1:0];
  assign size = shift_nxt[cbs_pkg::RATE_W +: cbs_pkg::SIZE_W];
  assign chan_id = wide_r ? {prior_nxt, shift_nxt[cbs_pkg::HDR_W-1 -: 16]}
                          : {16'd0, shift_nxt[cbs_pkg::HDR_W-1 -: 16]};

  // size*(rate-1)+8 drops below the four header bytes only for a zero rate with size above 4;
  // flag that as malformed and compute the length unsigned otherwise.
  assign prod = size * rate;
  assign bad  = (rate == '0) && (size > cbs_pkg::MAX_SHORT_SIZE);
  always_comb begin
    if (size == '0) begin
      len_wide = {6'd0, rate[cbs_pkg::RATE_W-1:1]} + cbs_pkg::LEN_BIAS;
    end else begin
      len_wide = {1'b0, prod} + cbs_pkg::LEN_BIAS - {13'd0, size};
    end
  end
  assign len       = len_wide[cbs_pkg::LEN_W-1:0];
  assign block_end = next_base + {{(cbs_pkg::ADDR_W-cbs_pkg::LEN_W){1'b0}}, len};
  // Compare against the limit as this byte leaves it: a layout change in the
  // middle of a record can put the size capture on a header's last byte.
  assign last      = bad || (block_end >= limit_nxt);

  // Advance to the next header, or drop out of the record on the last one.
  always_comb begin
    phase_nxt    = phase_r;
    next_hdr_nxt = next_base;
    hdr_end_nxt  = hdr_end_base;
    count_nxt    = count_base;
    if (start) begin
      phase_nxt = cbs_pkg::PH_SCAN;
    end
    if (hit) begin
      count_nxt = count_base + 1'b1;
      if (last) begin
        phase_nxt = cbs_pkg::PH_IDLE;
      end else begin
        next_hdr_nxt = block_end + (ext_r ? cbs_pkg::PREFIX_EXT : '0);
        hdr_end_nxt  = block_end + (ext_r ? cbs_pkg::PREFIX_EXT + cbs_pkg::HDR_TAIL
                                          : cbs_pkg::HDR_TAIL);
      end
    end
  end

  // Hold a result until its transfer; load a new one in the same cycle.
  assign out_valid_nxt = (accept && hit) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r       <= 1'b0;
      wide_r      <= 1'b0;
      phase_r     <= cbs_pkg::PH_IDLE;
      pos_r       <= '0;
      limit_r     <= '0;
      shift_r     <= '0;
      prior_r     <= '0;
      next_hdr_r  <= '0;
      hdr_end_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cbs_pkg::CFG_EXTENDED_LAYOUT: ext_r  <= cfg_wdata;
          cbs_pkg::CFG_WIDE_CHANNEL:    wide_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && active) begin
        phase_r    <= phase_nxt;
        pos_r      <= pos_nxt;
        limit_r    <= limit_nxt;
        shift_r    <= shift_nxt;
        prior_r    <= prior_nxt;
        next_hdr_r <= next_hdr_nxt;
        hdr_end_r  <= hdr_end_nxt;
        count_r    <= count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (accept && hit) begin
      out_data_r <= {count_base, size, rate, chan_id};
      out_last_r <= last;
      out_bad_r  <= bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

endmodule

`default_nettype wire

FILE: hdl/cbs_checker.sv
`default_nettype none

module cbs_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [cbs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic                             out_tlast,
  input wire logic                             out_tuser
);

  // No result survives reset.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                                  && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // A malformed channel always ends the record.
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("malformed channel without last flag");

  // Only a zero rate with a size code above 4 gives a length under the header.
  a_bad_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[cbs_pkg::RATE_LSB +: cbs_pkg::RATE_W] == '0 &&
      out_tdata[cbs_pkg::SIZE_LSB +: cbs_pkg::SIZE_W] > cbs_pkg::MAX_SHORT_SIZE)
    else $error("malformed flag on a valid block length");

  // An empty result register never stalls the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

bind channel_block_scanner_core cbs_checker u_cbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: tb/channel_block_scanner_core_test.sv
module channel_block_scanner_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One decoded channel block header, in the order the result stream carries it.
  typedef struct packed {
    logic [cbs_pkg::ID_W-1:0]   id;
    logic [cbs_pkg::RATE_W-1:0] rate;
    logic [cbs_pkg::SIZE_W-1:0] size_code;
    logic [cbs_pkg::IDX_W-1:0]  idx;
    logic                       last_ch;
    logic                       malformed;
  } chan_t;

  // One row of the directed part: a record byte, its start flag, and, where the
  // answer is obvious, the channel that its transfer must produce.
  typedef struct packed {
    logic [cbs_pkg::BYTE_W-1:0] b;
    logic                       st;
    logic                       typed;
    chan_t                      exp;
  } row_t;

  localparam int    HDR_BYTES   = 4;     // a channel block header is four bytes
  localparam int    PHASES      = 8;     // register settings in the random part
  localparam int    PHASE_ITEMS = 100;   // accepted bytes per setting, roughly
  localparam int    QUIET_LIMIT = 1000;  // cycles without any transfer
  localparam chan_t NO_RES      = '0;
  // Malformed header with every narrow id bit set and the largest size code: the
  // length goes negative, so the record closes on its first channel.
  localparam chan_t BAD_FIRST   = '{32'h0000_FFFF, 12'h000, 4'hF, 16'd0, 1'b1, 1'b1};

  // Directed part, register reset values (standard layout, narrow id):
  //   a stray byte before any record, a record cut short by a new start,
  //   a record whose size field is all ones with one malformed header,
  //   and a byte after that record has closed.
  localparam row_t DIRECTED_ROWS [0:18] = '{
    '{8'hFF, 1'b0, 1'b0, NO_RES},   // no record open: drop
    '{8'h00, 1'b1, 1'b0, NO_RES},   // record opened ...
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},   // ... and abandoned by the next start
    '{8'hFF, 1'b1, 1'b0, NO_RES},   // size bytes 0..3: limit 0xFFFFFFFF
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},   // record header filler, bytes 4..9
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h55, 1'b0, 1'b0, NO_RES},
    '{8'hAA, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},   // channel id 0xFFFF
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'hF0, 1'b0, 1'b0, NO_RES},   // size code 15, rate 0
    '{8'h00, 1'b0, 1'b1, BAD_FIRST},
    '{8'h7E, 1'b0, 1'b0, NO_RES}    // record closed: drop
  };

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic                            cfg_index  = cbs_pkg::CFG_EXTENDED_LAYOUT;
  logic                            cfg_wdata  = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [cbs_pkg::BYTE_W-1:0]      in_tdata   = '0;
  logic                            in_tuser   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [cbs_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;
  logic                            out_tuser;

  // Side band that travels with each input transfer: set when the row carries
  // its own expected channel instead of the scanner model's.
  logic  row_typed = 1'b0;
  chan_t row_exp   = '0;

  // Scanner model state, at its reset values.
  logic                        ext_on     = 1'b0;
  logic                        wide_on    = 1'b0;
  cbs_pkg::phase_t             scan_state = cbs_pkg::PH_IDLE;
  logic [cbs_pkg::POS_W-1:0]   pos        = '0;
  longint unsigned             lim        = 0;
  logic [cbs_pkg::HDR_W-1:0]   shreg      = '0;
  logic [cbs_pkg::PRIOR_W-1:0] prior      = '0;
  longint unsigned             next_hdr   = 0;
  logic [cbs_pkg::IDX_W-1:0]   chans      = '0;

  chan_t chan_q [$];       // channels announced but not yet seen on the output
  int    fails        = 0;
  int    quiet_cycles = 0;
  int    steady_left  = 0;
  int    bytes_used   = 0;
  int    bytes_dropped = 0;
  int    records      = 0;
  int    results_seen = 0;
  int    lasts_seen   = 0;
  int    bads_seen    = 0;

  channel_block_scanner_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [7:0] data_byte
    .in_tuser  (in_tuser),    // [0] record_start
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // [31:0] channel_id, [43:32] sample_rate, [47:44] sample_size_code,
    // [63:48] channel_index
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),   // last_channel
    .out_tuser (out_tuser)    // [0] malformed
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Block length in bytes, header included; negative for some bad headers.
  function automatic int blk_len(logic [cbs_pkg::SIZE_W-1:0] s,
                                 logic [cbs_pkg::RATE_W-1:0] rt);
    if (s == 0) return int'(rt >> 1) + int'(cbs_pkg::LEN_BIAS);
    return int'(s) * (int'(rt) - 1) + int'(cbs_pkg::LEN_BIAS);
  endfunction

  // Advance the scanner model by one accepted byte. used is low when the byte
  // falls outside any record; hit is high when it completes a block header.
  task automatic scan_byte(input logic [cbs_pkg::BYTE_W-1:0] b, input logic st,
                           output bit hit, output bit used, output chan_t r);
    int              len;
    longint unsigned blk_end;
    hit  = 1'b0;
    used = 1'b1;
    r    = '0;
    if (st) begin
      scan_state = cbs_pkg::PH_SCAN;
      pos        = '0;
      lim        = 0;
      shreg      = '0;
      prior      = '0;
      chans      = '0;
      next_hdr   = ext_on ? 64'(cbs_pkg::FIRST_HDR_EXT) : 64'(cbs_pkg::FIRST_HDR_STD);
    end else if (scan_state != cbs_pkg::PH_SCAN) begin
      used = 1'b0;
      return;
    end else if (pos != '1) begin
      pos = pos + 1'b1;             // saturate at the top
    end
    prior = {prior[7:0], shreg[31:24]};
    shreg = {shreg[23:0], b};
    if (!ext_on && pos == cbs_pkg::LIMIT_POS_STD) lim = 64'(shreg);
    if (ext_on && pos == cbs_pkg::LIMIT_POS_EXT)
      lim = 64'(shreg) + 64'(cbs_pkg::LIMIT_BIAS_EXT);
    if (64'(pos) != next_hdr + 64'(cbs_pkg::HDR_TAIL)) return;

    r.id        = wide_on ? {prior, shreg[31:16]} : {16'h0000, shreg[31:16]};
    r.rate      = shreg[11:0];
    r.size_code = shreg[15:12];
    r.idx       = chans;
    len         = blk_len(r.size_code, r.rate);
    if (len < HDR_BYTES) begin
      r.malformed = 1'b1;
      r.last_ch   = 1'b1;
      scan_state  = cbs_pkg::PH_IDLE;
    end else begin
      blk_end   = next_hdr + 64'(len);
      r.last_ch = (blk_end >= lim);
      if (r.last_ch) scan_state = cbs_pkg::PH_IDLE;
      else next_hdr = blk_end + (ext_on ? 64'(cbs_pkg::PREFIX_EXT) : 64'd0);
    end
    chans = chans + 1'b1;
    hit   = 1'b1;
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  // Mostly back-to-back, some short gaps, a few long ones, and now and then a
  // steady run with no gap at all.
  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      steady_left = $urandom_range(40, 120);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Offer one byte and hold it until the transfer happens. Keep valid high
  // when the next byte follows without a gap.
  task automatic send_byte(input logic [cbs_pkg::BYTE_W-1:0] b, input logic st,
                           input logic typed, input chan_t exp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= st;
    row_typed <= typed;
    row_exp   <= exp;
    do @(posedge clk); while (!in_tready);
  endtask

  // Build one record with one to five channel blocks and stream it. Most
  // records are well formed and close on their last channel; the rest carry a
  // malformed header, a limit of zero, a limit out of reach, or get cut short.
  task automatic play_record(input logic ext);
    logic [cbs_pkg::SIZE_W-1:0] s;
    logic [cbs_pkg::RATE_W-1:0] rt;
    logic [cbs_pkg::SIZE_W-1:0] bsize [$];
    logic [cbs_pkg::RATE_W-1:0] brate [$];
    longint unsigned            hdr_at [$];
    logic [cbs_pkg::BYTE_W-1:0] bytes [$];
    longint unsigned            at;
    longint unsigned            rec_lim;
    logic [31:0]                size_field;
    int                         nch, mode, span, body, keep, base;
    bit                         bad;
    nch = $urandom_range(1, 5);
    bad = ($urandom_range(0, 99) < 8);
    at  = ext ? 64'(cbs_pkg::FIRST_HDR_EXT) : 64'(cbs_pkg::FIRST_HDR_STD);
    for (int k = 0; k < nch; k++) begin
      s = cbs_pkg::SIZE_W'($urandom_range(0, 15));
      if (k == nch - 1 && bad) begin
        // rate 0 with a size code above four gives a length under the header
        s  = cbs_pkg::SIZE_W'($urandom_range(int'(cbs_pkg::MAX_SHORT_SIZE) + 1, 15));
        rt = '0;
      end else if (k == nch - 1 && $urandom_range(0, 4) == 0) begin
        rt = cbs_pkg::RATE_W'($urandom);   // any rate on the closing block
        if (rt == 0 && s > cbs_pkg::MAX_SHORT_SIZE) rt = 1;
      end else if (s == 0) begin
        rt = ($urandom_range(0, 19) == 0) ? cbs_pkg::RATE_W'($urandom_range(0, 400))
                                          : cbs_pkg::RATE_W'($urandom_range(0, 48));
      end else begin
        rt = (s <= cbs_pkg::MAX_SHORT_SIZE && $urandom_range(0, 3) == 0)
             ? cbs_pkg::RATE_W'(0) : cbs_pkg::RATE_W'($urandom_range(1, 4));
      end
      hdr_at.push_back(at);
      bsize.push_back(s);
      brate.push_back(rt);
      if (!(k == nch - 1 && bad))
        at = at + 64'(blk_len(s, rt)) + (ext ? 64'(cbs_pkg::PREFIX_EXT) : 64'd0);
    end

    // Pick the limit so that, in the common case, only the last block reaches it.
    span = blk_len(bsize[nch-1], brate[nch-1]);
    mode = $urandom_range(0, 99);
    if (bad) rec_lim = hdr_at[nch-1] + 64'($urandom_range(1, 1000));
    else if (mode < 70)
      rec_lim = hdr_at[nch-1] + 64'(span) - 64'($urandom_range(0, span - 1));
    else if (mode < 80) rec_lim = 0;
    else if (mode < 90)
      rec_lim = hdr_at[nch-1] + 64'(span) + 64'($urandom_range(1, 50));
    else rec_lim = 64'($urandom);
    size_field = 32'(rec_lim - (ext ? 64'(cbs_pkg::LIMIT_BIAS_EXT) : 64'd0));
    if (mode >= 95) size_field = '1;

    // Record header with the big-endian size, then the channel blocks.
    base = ext ? int'(cbs_pkg::LIMIT_POS_EXT) - 3 : int'(cbs_pkg::LIMIT_POS_STD) - 3;
    for (int i = 0; i < int'(ext ? cbs_pkg::FIRST_HDR_EXT : cbs_pkg::FIRST_HDR_STD); i++)
      bytes.push_back(cbs_pkg::BYTE_W'($urandom));
    for (int j = 0; j < 4; j++) bytes[base + j] = size_field[8*(3-j) +: 8];
    for (int k = 0; k < nch; k++) begin
      if (ext && k > 0) begin
        bytes.push_back(cbs_pkg::BYTE_W'($urandom));   // two-byte channel prefix
        bytes.push_back(cbs_pkg::BYTE_W'($urandom));
      end
      bytes.push_back(cbs_pkg::BYTE_W'($urandom));     // channel id, high byte first
      bytes.push_back(cbs_pkg::BYTE_W'($urandom));
      bytes.push_back({bsize[k], brate[k][11:8]});
      bytes.push_back(brate[k][7:0]);
      // after the last header send only a few bytes; the record may be over
      body = (k == nch - 1) ? $urandom_range(0, 6)
                            : blk_len(bsize[k], brate[k]) - HDR_BYTES;
      repeat (body) bytes.push_back(cbs_pkg::BYTE_W'($urandom));
    end

    keep = bytes.size();
    if ($urandom_range(0, 9) == 0) keep = $urandom_range(1, bytes.size());
    for (int i = 0; i < keep; i++) send_byte(bytes[i], i == 0, 1'b0, NO_RES);
    records++;
  endtask

  // Drop valid, let the monitor log the last transfer, wait for every
  // announced channel, then let the result register settle before anything
  // touches the registers.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (chan_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: long ready stretches, short bursts, short and long stalls.
  initial begin
    int r, n;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        out_tready <= 1'b1;
        n = $urandom_range(60, 150);
      end else if (r < 65) begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 8);
      end else if (r < 95) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        out_tready <= 1'b0;
        n = $urandom_range(15, 40);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Monitor: track register writes, check each result transfer against the
  // oldest announced channel, and run the scanner model on each input transfer.
  always @(posedge clk) begin
    chan_t seen, want, pred;
    bit    hit, used;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          cbs_pkg::CFG_EXTENDED_LAYOUT: ext_on  = cfg_wdata;
          cbs_pkg::CFG_WIDE_CHANNEL:    wide_on = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        seen = {out_tdata[cbs_pkg::ID_W-1:0],
                out_tdata[cbs_pkg::RATE_LSB +: cbs_pkg::RATE_W],
                out_tdata[cbs_pkg::SIZE_LSB +: cbs_pkg::SIZE_W],
                out_tdata[cbs_pkg::IDX_LSB +: cbs_pkg::IDX_W],
                out_tlast, out_tuser};
        if (chan_q.size() == 0) begin
          $error("result transfer with no channel pending: tdata 0x%0h", out_tdata);
          fails++;
        end else begin
          want = chan_q.pop_front();
          check_field("channel_id", want.id, seen.id);
          check_field("sample_rate", want.rate, seen.rate);
          check_field("sample_size_code", want.size_code, seen.size_code);
          check_field("channel_index", want.idx, seen.idx);
          check_field("last_channel", want.last_ch, seen.last_ch);
          check_field("malformed", want.malformed, seen.malformed);
          results_seen++;
          if (seen.last_ch) lasts_seen++;
          if (seen.malformed) bads_seen++;
        end
      end
      if (in_tvalid && in_tready) begin
        scan_byte(in_tdata, in_tuser, hit, used, pred);
        if (used) bytes_used++;
        else bytes_dropped++;
        if (row_typed) chan_q.push_back(row_exp);
        else if (hit) chan_q.push_back(pred);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic ext, wide;
    int   goal;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the register reset values.
    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].st,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp);

    // Random part: walk all four corner settings, then random ones. Write the
    // registers only once the scanner has gone quiet; every record after the
    // write opens with a start byte, so no record straddles a setting.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       {ext, wide} = 2'b11;
        1:       {ext, wide} = 2'b01;
        2:       {ext, wide} = 2'b10;
        3:       {ext, wide} = 2'b00;
        default: {ext, wide} = 2'($urandom);
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= cbs_pkg::CFG_EXTENDED_LAYOUT;
      cfg_wdata <= ext;
      @(posedge clk);
      cfg_index <= cbs_pkg::CFG_WIDE_CHANNEL;
      cfg_wdata <= wide;
      @(posedge clk);
      cfg_we    <= 1'b0;
      goal = bytes_used + bytes_dropped + PHASE_ITEMS;
      while (bytes_used + bytes_dropped < goal) play_record(ext);
    end

    drain();
    repeat (8) @(posedge clk);
    if (chan_q.size() != 0) begin
      $error("%0d channels never came out", chan_q.size());
      fails++;
    end

    $display("Scanned %0d bytes in %0d random records over %0d register settings",
             bytes_used, records, PHASES + 1);
    $display("Dropped %0d bytes outside records; checked %0d channels: %0d closed a %s",
             bytes_dropped, results_seen, lasts_seen, "record");
    $display("Malformed channels seen: %0d", bads_seen);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
